@@ hw/rtl/rrm_pkg.sv @@
// ----------------------------------------------------------------------------
// rrm_pkg
// Shared types and codes for the round-robin ring manager: request and status
// codes, transfer payloads, sequencer states and ring storage controls.
// ----------------------------------------------------------------------------
package rrm_pkg;

  localparam int ID_W = 16;

  // request codes
  localparam logic [2:0] REQ_ADD    = 3'd0;
  localparam logic [2:0] REQ_REMOVE = 3'd1;
  localparam logic [2:0] REQ_NEXT   = 3'd2;
  localparam logic [2:0] REQ_SKIP   = 3'd3;
  localparam logic [2:0] REQ_LIST   = 3'd4;

  // status codes
  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_EMPTY     = 2'd1;
  localparam logic [1:0] STAT_NOT_FOUND = 2'd2;
  localparam logic [1:0] STAT_FULL      = 2'd3;

  typedef struct packed {
    logic [2:0]      req_type;
    logic [ID_W-1:0] member_id;
  } in_item_t;

  typedef struct packed {
    logic [1:0]      status;
    logic [ID_W-1:0] shown_id;
    logic [4:0]      member_count;
    logic            one_left;
    logic            last_of_run;
  } out_item_t;

  // write strobes into the ring storage
  typedef struct packed {
    logic id_we;
    logic link_we;
    logic use_set;
    logic use_clr;
  } store_ctl_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ADD_SCAN,
    S_ADD_LINK,
    S_REM_RD,
    S_REM_CHK,
    S_STEP_RD,
    S_STEP_GO,
    S_LIST_RD,
    S_LIST_EMIT,
    S_RES_RD,
    S_RES_EMIT
  } state_t;

endpackage

@@ hw/rtl/round_robin_ring_manager.sv @@
// ----------------------------------------------------------------------------
// round_robin_ring_manager
// Ring of member ids kept in turn order with a current pointer; supports
// add, remove, next, skip and list, reporting count and winner on each result.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; busy then stays high
// while a small sequencer walks the ring through one registered memory read
// port, one slot per cycle. Add scans the in-use flags from slot 0 for the
// first free slot and, on a non-empty ring, links it behind the tail; remove
// compares entries along the links until a hit or the end of the ring; next
// advances the current pointer once and skip twice; list reads out every
// member. Full, empty and unused request codes go straight to the result.
// The single result of a request is strobed on out_valid in the first cycle
// with busy low; list strobes one result per cycle, the last one (marked by
// last_of_run) coinciding with busy going low. Results are shown for one
// cycle only and must be taken then, since the block cannot be stalled.
module round_robin_ring_manager #(
  parameter int MAX_MEMBERS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  rrm_pkg::in_item_t  in_item,
  output logic               out_valid,
  output rrm_pkg::out_item_t out_item
);
  import rrm_pkg::*;

  localparam int SW = $clog2(MAX_MEMBERS);
  localparam int CW = $clog2(MAX_MEMBERS + 1);

  state_t          state_r, state_nxt;
  logic [ID_W-1:0] id_r, id_nxt;
  logic [1:0]      status_r, status_nxt;
  logic [SW-1:0]   cur_r, cur_nxt;
  logic [SW-1:0]   tail_r, tail_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic [SW-1:0]   walk_r, walk_nxt;
  logic [SW-1:0]   prev_r, prev_nxt;
  logic [SW-1:0]   scan_r, scan_nxt;
  logic [CW-1:0]   iter_r, iter_nxt;
  logic            two_r, two_nxt;
  logic            out_valid_r, out_valid_nxt;
  out_item_t       out_item_r, out_item_nxt;

  store_ctl_t             ctl;
  logic [SW-1:0]          wr_addr;
  logic [SW-1:0]          link_addr;
  logic [SW-1:0]          link_data;
  logic [SW-1:0]          rd_addr;
  logic [ID_W-1:0]        rd_id;
  logic [SW-1:0]          rd_link;
  logic [MAX_MEMBERS-1:0] in_use;

  logic accept;
  logic empty;
  logic full;
  logic rem_hit;
  logic walk_end;
  logic scan_free;

  rrm_store #(
    .MAX_MEMBERS(MAX_MEMBERS)
  ) u_store (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (ctl),
    .wr_addr  (wr_addr),
    .wr_id    (id_r),
    .link_addr(link_addr),
    .link_data(link_data),
    .rd_addr  (rd_addr),
    .rd_id    (rd_id),
    .rd_link  (rd_link),
    .in_use   (in_use)
  );

  // shared conditions
  assign busy      = (state_r != S_IDLE);
  assign accept    = start && !busy;
  assign empty     = (count_r == '0);
  assign full      = (count_r >= CW'(MAX_MEMBERS));
  assign rem_hit   = (rd_id == id_r);
  assign walk_end  = ((iter_r + CW'(1)) == count_r);
  assign scan_free = !in_use[scan_r];

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (in_item.req_type)
            REQ_ADD:              state_nxt = full  ? S_RES_RD : S_ADD_SCAN;
            REQ_REMOVE:           state_nxt = empty ? S_RES_RD : S_REM_RD;
            REQ_NEXT, REQ_SKIP:   state_nxt = empty ? S_RES_RD : S_STEP_RD;
            REQ_LIST:             state_nxt = empty ? S_RES_RD : S_LIST_RD;
            default:              state_nxt = S_RES_RD;
          endcase
        end
      end
      S_ADD_SCAN: begin
        if (scan_free) begin
          state_nxt = empty ? S_RES_RD : S_ADD_LINK;
        end
      end
      S_ADD_LINK:  state_nxt = S_RES_RD;
      S_REM_RD:    state_nxt = S_REM_CHK;
      S_REM_CHK: begin
        if (rem_hit || walk_end) begin
          state_nxt = S_RES_RD;
        end
      end
      S_STEP_RD:   state_nxt = S_STEP_GO;
      S_STEP_GO:   state_nxt = two_r ? S_STEP_GO : S_RES_EMIT;
      S_LIST_RD:   state_nxt = S_LIST_EMIT;
      S_LIST_EMIT: state_nxt = walk_end ? S_IDLE : S_LIST_EMIT;
      S_RES_RD:    state_nxt = S_RES_EMIT;
      S_RES_EMIT:  state_nxt = S_IDLE;
      default:     state_nxt = S_IDLE;
    endcase
  end

  // datapath and storage controls
  always_comb begin
    id_nxt        = id_r;
    status_nxt    = status_r;
    cur_nxt       = cur_r;
    tail_nxt      = tail_r;
    count_nxt     = count_r;
    walk_nxt      = walk_r;
    prev_nxt      = prev_r;
    scan_nxt      = scan_r;
    iter_nxt      = iter_r;
    two_nxt       = two_r;
    out_valid_nxt = 1'b0;
    out_item_nxt  = out_item_r;
    ctl           = '0;
    wr_addr       = scan_r;
    link_addr     = scan_r;
    link_data     = cur_r;
    rd_addr       = cur_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          id_nxt   = in_item.member_id;
          walk_nxt = cur_r;
          prev_nxt = tail_r;
          scan_nxt = '0;
          iter_nxt = '0;
          two_nxt  = (in_item.req_type == REQ_SKIP);
          if (in_item.req_type == REQ_ADD) begin
            status_nxt = full ? STAT_FULL : STAT_OK;
          end else begin
            status_nxt = empty ? STAT_EMPTY : STAT_OK;
          end
        end
      end
      // claim the lowest free slot, link it to current
      S_ADD_SCAN: begin
        if (scan_free) begin
          ctl.id_we   = 1'b1;
          ctl.link_we = 1'b1;
          ctl.use_set = 1'b1;
          link_data   = empty ? scan_r : cur_r;
          if (empty) begin
            cur_nxt   = scan_r;
            tail_nxt  = scan_r;
            count_nxt = count_r + CW'(1);
          end
        end else begin
          scan_nxt = scan_r + SW'(1);
        end
      end
      // old tail now points at the new slot
      S_ADD_LINK: begin
        ctl.link_we = 1'b1;
        link_addr   = tail_r;
        link_data   = scan_r;
        tail_nxt    = scan_r;
        count_nxt   = count_r + CW'(1);
      end
      S_REM_RD: begin
        rd_addr = walk_r;
      end
      // compare one entry per cycle, following the links
      S_REM_CHK: begin
        if (rem_hit) begin
          ctl.use_clr = 1'b1;
          wr_addr     = walk_r;
          if (count_r == CW'(1)) begin
            count_nxt = '0;
            cur_nxt   = '0;
            tail_nxt  = '0;
          end else begin
            ctl.link_we = 1'b1;
            link_addr   = prev_r;
            link_data   = rd_link;
            if (walk_r == cur_r) begin
              cur_nxt = rd_link;
            end
            if (walk_r == tail_r) begin
              tail_nxt = prev_r;
            end
            count_nxt = count_r - CW'(1);
          end
        end else begin
          prev_nxt = walk_r;
          walk_nxt = rd_link;
          iter_nxt = iter_r + CW'(1);
          rd_addr  = rd_link;
          if (walk_end) begin
            status_nxt = STAT_NOT_FOUND;
          end
        end
      end
      S_STEP_RD: begin
        rd_addr = cur_r;
      end
      // advance current; the read of the new current feeds the result
      S_STEP_GO: begin
        tail_nxt = cur_r;
        cur_nxt  = rd_link;
        rd_addr  = rd_link;
        two_nxt  = 1'b0;
      end
      S_LIST_RD: begin
        rd_addr = cur_r;
      end
      // one listed member per cycle
      S_LIST_EMIT: begin
        rd_addr                   = rd_link;
        iter_nxt                  = iter_r + CW'(1);
        out_valid_nxt             = 1'b1;
        out_item_nxt.status       = STAT_OK;
        out_item_nxt.shown_id     = rd_id;
        out_item_nxt.member_count = 5'(count_r);
        out_item_nxt.one_left     = (count_r == CW'(1));
        out_item_nxt.last_of_run  = walk_end;
      end
      S_RES_RD: begin
        rd_addr = cur_r;
      end
      S_RES_EMIT: begin
        out_valid_nxt             = 1'b1;
        out_item_nxt.status       = status_r;
        out_item_nxt.shown_id     = empty ? '0 : rd_id;
        out_item_nxt.member_count = 5'(count_r);
        out_item_nxt.one_left     = (count_r == CW'(1));
        out_item_nxt.last_of_run  = 1'b1;
      end
      default: begin
        rd_addr = cur_r;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cur_r       <= '0;
      tail_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cur_r       <= cur_nxt;
      tail_r      <= tail_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    id_r       <= id_nxt;
    status_r   <= status_nxt;
    walk_r     <= walk_nxt;
    prev_r     <= prev_nxt;
    scan_r     <= scan_nxt;
    iter_r     <= iter_nxt;
    two_r      <= two_nxt;
    out_item_r <= out_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

`ifndef SYNTHESIS
  // occupancy flags agree with the member count between requests
  a_count_matches_flags: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> ($countones(in_use) == count_r))
    else $error("in-use flags disagree with member count");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(MAX_MEMBERS))
    else $error("member count exceeds ring size");

  // a list run continues until its last transfer
  a_list_continues: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_item.last_of_run) |=> out_valid)
    else $error("list run broken before last transfer");

  // the final transfer of a request leaves the block free
  a_last_frees: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.last_of_run) |-> !busy)
    else $error("still busy on final transfer");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("request taken without going busy");
`endif

endmodule

@@ hw/rtl/rrm_store.sv @@
// ----------------------------------------------------------------------------
// rrm_store
// Ring storage: member id memory and next-link memory, each with one write
// port and one registered read port, plus the per-slot in-use flags.
// ----------------------------------------------------------------------------
module rrm_store #(
  parameter int MAX_MEMBERS = 16,
  localparam int SW = $clog2(MAX_MEMBERS)
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  rrm_pkg::store_ctl_t      ctl,
  input  logic [SW-1:0]            wr_addr,
  input  logic [rrm_pkg::ID_W-1:0] wr_id,
  input  logic [SW-1:0]            link_addr,
  input  logic [SW-1:0]            link_data,
  input  logic [SW-1:0]            rd_addr,
  output logic [rrm_pkg::ID_W-1:0] rd_id,
  output logic [SW-1:0]            rd_link,
  output logic [MAX_MEMBERS-1:0]   in_use
);
  import rrm_pkg::*;

  logic [ID_W-1:0]        id_mem   [MAX_MEMBERS];
  logic [SW-1:0]          link_mem [MAX_MEMBERS];
  logic [MAX_MEMBERS-1:0] in_use_r;

  // id memory
  always_ff @(posedge clk) begin
    if (ctl.id_we) begin
      id_mem[wr_addr] <= wr_id;
    end
    rd_id <= id_mem[rd_addr];
  end

  // link memory
  always_ff @(posedge clk) begin
    if (ctl.link_we) begin
      link_mem[link_addr] <= link_data;
    end
    rd_link <= link_mem[rd_addr];
  end

  // occupancy flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_use_r <= '0;
    end else if (ctl.use_set) begin
      in_use_r[wr_addr] <= 1'b1;
    end else if (ctl.use_clr) begin
      in_use_r[wr_addr] <= 1'b0;
    end
  end

  assign in_use = in_use_r;

endmodule

@@ tb/round_robin_ring_manager_tb.sv @@
// ----------------------------------------------------------------------------
// round_robin_ring_manager_tb
// Self-checking bench for the ring manager. Requests are sent with random
// gaps and checked against a cycle-free ring predictor. The bench starts with
// a short directed pass over the empty ring, one and two members, duplicate
// ids and miss cases. It then sends random blocks that fill the ring,
// churn it and drain it.
// ----------------------------------------------------------------------------
module round_robin_ring_manager_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rrm_pkg::*;

  localparam int RING_SLOTS   = 16;
  localparam int RANDOM_ITEMS = 300;
  localparam int BLOCK_LEN    = 25;
  localparam int IDLE_LIMIT   = 2000;
  localparam int DRAIN_CYCLES = 40;

  // request codes with no function, answered with the current state
  localparam logic [2:0] REQ_SPARE_5 = 3'd5;
  localparam logic [2:0] REQ_SPARE_6 = 3'd6;
  localparam logic [2:0] REQ_SPARE_7 = 3'd7;

  // random block flavors
  typedef enum int {BLK_GROW, BLK_CHURN, BLK_SHRINK} block_kind_t;

  // ring predictor and queue of expected results
  class ring_scoreboard;
    logic [ID_W-1:0] slot_id[RING_SLOTS];
    logic [3:0]      slot_next[RING_SLOTS];
    bit              slot_used[RING_SLOTS];
    int unsigned     cur_slot, tail_slot, members;
    out_item_t       expected_q[$];
    int unsigned     errors, checked, full_hits, peak_members;

    function new();
      foreach (slot_used[i]) slot_used[i] = 1'b0;
      cur_slot = 0; tail_slot = 0; members = 0;
      errors = 0; checked = 0; full_hits = 0; peak_members = 0;
    endfunction

    function logic [ID_W-1:0] current_id();
      return (members == 0) ? '0 : slot_id[cur_slot];
    endfunction

    function void push_result(logic [1:0] st, logic [ID_W-1:0] id, bit last);
      out_item_t r;
      r.status       = st;
      r.shown_id     = id;
      r.member_count = 5'(members);
      r.one_left     = (members == 1);
      r.last_of_run  = last;
      expected_q.push_back(r);
    endfunction

    // random id of a member now in the ring
    function logic [ID_W-1:0] some_member();
      int unsigned s, hops;
      s = cur_slot;
      hops = $urandom_range(0, members - 1);
      repeat (hops) s = slot_next[s];
      return slot_id[s];
    endfunction

    // work out the results of one accepted request
    function void note_request(in_item_t it);
      int unsigned free_slot, s, prev, nxt, steps;
      bit found;
      free_slot = RING_SLOTS;
      found = 1'b0;
      if (it.req_type == REQ_ADD) begin
        for (int i = 0; i < RING_SLOTS; i++) begin
          if (!slot_used[i] && free_slot == RING_SLOTS) free_slot = i;
        end
        if (members >= RING_SLOTS || free_slot == RING_SLOTS) begin
          full_hits++;
          push_result(STAT_FULL, current_id(), 1'b1);
          return;
        end
        slot_id[free_slot]   = it.member_id;
        slot_used[free_slot] = 1'b1;
        if (members == 0) begin
          slot_next[free_slot] = 4'(free_slot);
          cur_slot = free_slot;
        end else begin
          slot_next[tail_slot] = 4'(free_slot);
          slot_next[free_slot] = 4'(cur_slot);
        end
        tail_slot = free_slot;
        members++;
        if (members > peak_members) peak_members = members;
        push_result(STAT_OK, current_id(), 1'b1);
        return;
      end
      if (it.req_type > REQ_LIST) begin
        push_result(members == 0 ? STAT_EMPTY : STAT_OK, current_id(), 1'b1);
        return;
      end
      if (members == 0) begin
        push_result(STAT_EMPTY, '0, 1'b1);
        return;
      end
      case (it.req_type)
        REQ_REMOVE: begin
          s = cur_slot;
          prev = tail_slot;
          for (int i = 0; i < members && !found; i++) begin
            if (slot_id[s] == it.member_id) begin
              found = 1'b1;
              nxt = slot_next[s];
              slot_used[s] = 1'b0;
              if (members == 1) begin
                members = 0; cur_slot = 0; tail_slot = 0;
              end else begin
                slot_next[prev] = 4'(nxt);
                if (s == cur_slot) cur_slot = nxt;
                if (s == tail_slot) tail_slot = prev;
                members--;
              end
            end else begin
              prev = s;
              s = slot_next[s];
            end
          end
          push_result(found ? STAT_OK : STAT_NOT_FOUND, current_id(), 1'b1);
        end
        REQ_NEXT, REQ_SKIP: begin
          steps = (it.req_type == REQ_NEXT) ? 1 : 2;
          repeat (steps) begin
            tail_slot = cur_slot;
            cur_slot = slot_next[cur_slot];
          end
          push_result(STAT_OK, current_id(), 1'b1);
        end
        default: begin
          s = cur_slot;
          for (int i = 0; i < members; i++) begin
            push_result(STAT_OK, slot_id[s], i + 1 == members);
            s = slot_next[s];
          end
        end
      endcase
    endfunction

    // compare one strobed result with the oldest expectation
    function void check_result(out_item_t got);
      out_item_t exp_r;
      if (expected_q.size() == 0) begin
        $error("result with nothing expected: %p", got);
        errors++;
        return;
      end
      exp_r = expected_q.pop_front();
      checked++;
      if (got.status !== exp_r.status) begin
        $error("status: expected %0d, got %0d", exp_r.status, got.status);
        errors++;
      end
      if (got.shown_id !== exp_r.shown_id) begin
        $error("shown_id: expected %0h, got %0h", exp_r.shown_id, got.shown_id);
        errors++;
      end
      if (got.member_count !== exp_r.member_count) begin
        $error("member_count: expected %0d, got %0d", exp_r.member_count,
               got.member_count);
        errors++;
      end
      if (got.one_left !== exp_r.one_left) begin
        $error("one_left: expected %0b, got %0b", exp_r.one_left, got.one_left);
        errors++;
      end
      if (got.last_of_run !== exp_r.last_of_run) begin
        $error("last_of_run: expected %0b, got %0b", exp_r.last_of_run,
               got.last_of_run);
        errors++;
      end
    endfunction
  endclass

  logic      clk;
  logic      rst_n;
  logic      start;
  logic      busy;
  in_item_t  in_item;
  logic      out_valid;
  out_item_t out_item;

  ring_scoreboard sb;
  int unsigned    idle_cycles;
  int unsigned    req_seen[8];
  bit             burst_mode;

  round_robin_ring_manager #(.MAX_MEMBERS(RING_SLOTS)) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_item (out_item)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_valid) sb.check_result(out_item);
  end

  // cycles with neither a request transfer nor a result
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  // hang detection
  initial begin
    wait (idle_cycles >= IDLE_LIMIT);
    $display("Verification failed");
    $finish;
  end

  // id with extremes, a small pool for duplicates and full-range values
  function automatic logic [ID_W-1:0] draw_id();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    if (r < 6) return ID_W'($urandom_range(1, 6));
    return ID_W'($urandom_range(0, 65535));
  endfunction

  // one request transfer, entered and left at a falling edge
  task automatic send_request(logic [2:0] req, logic [ID_W-1:0] id);
    in_item_t it;
    int unsigned gap;
    it.req_type  = req;
    it.member_id = id;
    gap = burst_mode ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start   <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (busy);
    sb.note_request(it);
    req_seen[req]++;
    @(negedge clk);
  endtask

  // request mix for one block of random traffic
  task automatic send_random(block_kind_t kind);
    int unsigned r, add_pct, rem_pct;
    logic [ID_W-1:0] id;
    case (kind)
      BLK_GROW:  begin add_pct = 65; rem_pct = 10; end
      BLK_CHURN: begin add_pct = 35; rem_pct = 30; end
      default:   begin add_pct = 10; rem_pct = 65; end
    endcase
    r = $urandom_range(0, 99);
    if (r < add_pct) begin
      send_request(REQ_ADD, draw_id());
    end else if (r < add_pct + rem_pct) begin
      // mostly ids that are in the ring, sometimes a likely miss
      id = (sb.members > 0 && $urandom_range(0, 9) < 8) ? sb.some_member() : draw_id();
      send_request(REQ_REMOVE, id);
    end else begin
      r = $urandom_range(0, 19);
      if (r < 7) send_request(REQ_NEXT, draw_id());
      else if (r < 13) send_request(REQ_SKIP, draw_id());
      else if (r < 17) send_request(REQ_LIST, draw_id());
      else send_request(3'($urandom_range(REQ_SPARE_5, REQ_SPARE_7)), draw_id());
    end
  endtask

  // stimulus and end of run
  initial begin
    sb = new();
    foreach (req_seen[i]) req_seen[i] = 0;
    burst_mode = 1'b0;
    rst_n   = 1'b0;
    start   = 1'b0;
    in_item = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // empty ring on remove, next, skip, list and two spare codes
    send_request(REQ_REMOVE, '1);
    send_request(REQ_NEXT, '0);
    send_request(REQ_SKIP, '1);
    send_request(REQ_LIST, '0);
    send_request(REQ_SPARE_5, '1);
    send_request(REQ_SPARE_7, '0);
    // one and two members, duplicate ids, skip wrapping around
    send_request(REQ_ADD, '0);
    send_request(REQ_SKIP, '0);
    send_request(REQ_SPARE_6, '1);
    send_request(REQ_ADD, '1);
    send_request(REQ_SKIP, '0);
    send_request(REQ_ADD, '1);
    send_request(REQ_LIST, '0);
    send_request(REQ_REMOVE, 16'h1234);
    send_request(REQ_NEXT, '0);
    send_request(REQ_REMOVE, '1);
    send_request(REQ_LIST, '0);
    // remove the current entry, then the last member
    send_request(REQ_REMOVE, sb.current_id());
    send_request(REQ_REMOVE, sb.current_id());
    send_request(REQ_LIST, '1);

    // random blocks: fill, churn, drain; every fourth block back to back
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      burst_mode = ((n / BLOCK_LEN) % 4) == 3;
      send_random(block_kind_t'((n / BLOCK_LEN) % 3));
    end
    start <= 1'b0;

    // drain outstanding results, then watch for strays
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.expected_q.size() != 0) begin
      $error("%0d expected results never arrived", sb.expected_q.size());
      sb.errors++;
    end
    $display("run: add %0d, remove %0d, next %0d, skip %0d, list %0d, spare codes %0d",
             req_seen[REQ_ADD], req_seen[REQ_REMOVE], req_seen[REQ_NEXT],
             req_seen[REQ_SKIP], req_seen[REQ_LIST],
             req_seen[REQ_SPARE_5] + req_seen[REQ_SPARE_6] + req_seen[REQ_SPARE_7]);
    $display("run: %0d results checked, ring peak %0d members, %0d adds on a full ring",
             sb.checked, sb.peak_members, sb.full_hits);
    if (sb.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
